// ===== sv/bsc_pkg.sv =====
// shared types, widths and constants for the barometric compensation core
// no dependencies; every other file refers to this package by scoped names
package bsc_pkg;

	localparam int NUM_W      = 62;
	localparam int DEN_W      = 46;
	localparam int QUO_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_A    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_B    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_C    = 2'd3;

	localparam logic signed [14:0] TEMP_MIN = -15'sd4000;
	localparam logic signed [14:0] TEMP_MAX = 15'sd8500;
	localparam logic [16:0]        PRES_MIN = 17'd30000;
	localparam logic [16:0]        PRES_MAX = 17'd110000;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
	} sample_t;

	typedef struct packed {
		logic signed [14:0] temperature_centi;
		logic [16:0]        pressure_pa;
		logic               divisor_invalid;
	} result_t;

	typedef struct packed {
		logic [15:0]        t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0]        p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} trim_t;

	// results that ride along with the pressure division
	typedef struct packed {
		logic signed [14:0] temperature_centi;
		logic               divisor_invalid;
	} side_t;

	function automatic logic [15:0] mag16(input logic signed [15:0] v);
		logic [15:0] u;
		u = v;
		mag16 = v[15] ? (~u + 16'd1) : u;
	endfunction

endpackage

// ===== sv/bsc_front.sv =====
// temperature formula and pressure polynomial up to numerator and divisor
// nine register stages; uses bsc_pkg
module bsc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  bsc_pkg::sample_t            sample,
	input  bsc_pkg::trim_t              trim,
	output logic                        out_valid,
	output logic [bsc_pkg::NUM_W-1:0]   num,
	output logic [bsc_pkg::DEN_W-1:0]   den,
	output bsc_pkg::side_t              side
);

	localparam logic signed [65:0] QMAX = 66'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [18:0] TLO  = 19'(bsc_pkg::TEMP_MIN);
	localparam logic signed [18:0] THI  = 19'(bsc_pkg::TEMP_MAX);

	function automatic logic signed [63:0] sat64(input logic signed [65:0] s);
		logic signed [65:0] lim;
		lim = QMAX;
		if (s > lim) begin
			sat64 = lim[63:0];
		end else if (s < -lim) begin
			sat64 = -(lim[63:0]);
		end else begin
			sat64 = s[63:0];
		end
	endfunction

	logic [8:0] vld_q;

	// stage 1
	logic signed [17:0] diff_a;
	logic signed [16:0] diff_b;
	logic [15:0]        mag_b;
	logic signed [33:0] prod_a_s1;
	logic [31:0]        bsq_s1;
	logic [19:0]        rawp_s1;

	assign diff_a = $signed({1'b0, sample.raw_temperature[19:3]})
		- $signed({1'b0, trim.t1, 1'b0});
	assign diff_b = $signed({1'b0, sample.raw_temperature[19:4]}) - $signed({1'b0, trim.t1});
	assign mag_b  = diff_b[16] ? 16'(-diff_b) : diff_b[15:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_a_s1 <= 34'(diff_a) * 34'(trim.t2);
			bsq_s1    <= 32'(mag_b) * 32'(mag_b);
			rawp_s1   <= sample.raw_pressure;
		end
	end

	// stage 2
	logic signed [33:0] a_round;
	logic signed [22:0] a_s2;
	logic signed [36:0] prod_b_s2;
	logic [19:0]        rawp_s2;

	assign a_round = prod_a_s1 + (prod_a_s1[33] ? 34'sd2047 : 34'sd0);

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2      <= a_round[33:11];
			prod_b_s2 <= 37'($signed({1'b0, bsq_s1[31:12]})) * 37'(trim.t3);
			rawp_s2   <= rawp_s1;
		end
	end

	// stage 3
	logic signed [36:0] b_round;
	logic signed [22:0] b_val;
	logic signed [23:0] fine;
	logic signed [23:0] fine_s3;
	logic signed [23:0] f1_s3;
	logic [19:0]        rawp_s3;

	assign b_round = prod_b_s2 + (prod_b_s2[36] ? 37'sd16383 : 37'sd0);
	assign b_val   = b_round[36:14];
	assign fine    = 24'(a_s2) + 24'(b_val);

	always_ff @(posedge clk) begin
		if (adv) begin
			fine_s3 <= fine;
			f1_s3   <= fine - 24'sd128000;
			rawp_s3 <= rawp_s2;
		end
	end

	// stage 4: temperature out, square of the offset fine value
	logic signed [26:0] t5;
	logic signed [26:0] t_round;
	logic signed [18:0] t_div;
	logic signed [14:0] temp;
	logic [23:0]        fmag;
	logic [47:0]        sq_s4;
	logic signed [39:0] v2b_s4;
	logic signed [39:0] v3c_s4;
	logic signed [14:0] temp_s4;
	logic [19:0]        rawp_s4;

	assign t5      = 27'(fine_s3) * 27'sd5 + 27'sd128;
	assign t_round = t5 + (t5[26] ? 27'sd255 : 27'sd0);
	assign t_div   = t_round[26:8];
	assign temp    = (t_div < TLO) ? bsc_pkg::TEMP_MIN :
		(t_div > THI) ? bsc_pkg::TEMP_MAX : t_div[14:0];
	assign fmag    = f1_s3[23] ? 24'(-f1_s3) : f1_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s4   <= 48'(fmag) * 48'(fmag);
			v2b_s4  <= 40'(f1_s3) * 40'(trim.p5);
			v3c_s4  <= 40'(f1_s3) * 40'(trim.p2);
			temp_s4 <= temp;
			rawp_s4 <= rawp_s3;
		end
	end

	// stage 5: square times p6 and p3 magnitudes
	logic [15:0]        m6;
	logic [15:0]        m3;
	logic               sat_s5;
	logic [56:0]        prod6_s5;
	logic [56:0]        prod3_s5;
	logic signed [39:0] v2b_s5;
	logic signed [39:0] v3c_s5;
	logic signed [14:0] temp_s5;
	logic [19:0]        rawp_s5;

	assign m6 = bsc_pkg::mag16(trim.p6);
	assign m3 = bsc_pkg::mag16(trim.p3);

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s5   <= |sq_s4[47:41];
			prod6_s5 <= 57'(sq_s4[40:0]) * 57'(m6);
			prod3_s5 <= 57'(sq_s4[40:0]) * 57'(m3);
			v2b_s5   <= v2b_s4;
			v3c_s5   <= v3c_s4;
			temp_s5  <= temp_s4;
			rawp_s5  <= rawp_s4;
		end
	end

	// stage 6: saturating sums of the two polynomial terms
	logic [63:0]        mag6;
	logic [63:0]        mag3;
	logic signed [65:0] v2a;
	logic signed [65:0] v3;
	logic signed [65:0] v2b_w;
	logic signed [65:0] v3c_w;
	logic signed [63:0] y_s6;
	logic signed [63:0] x_s6;
	logic signed [14:0] temp_s6;
	logic [19:0]        rawp_s6;

	// a saturated square times m over 2^sh comes out as m * 2^(63-sh) - 1
	assign mag6  = sat_s5 ? ((m6 == 16'd0) ? 64'd0 : {m6, 48'd0} - 64'd1)
		: {prod6_s5, 7'd0};
	assign mag3  = sat_s5 ? ((m3 == 16'd0) ? 64'd0 : 64'({m3, 44'd0}) - 64'd1)
		: 64'({prod3_s5, 3'd0});
	assign v2a   = trim.p6[15] ? -$signed({2'b00, mag6}) : $signed({2'b00, mag6});
	assign v3    = trim.p3[15] ? -$signed({2'b00, mag3}) : $signed({2'b00, mag3});
	assign v2b_w = 66'($signed({v2b_s5, 24'd0}));
	assign v3c_w = 66'($signed({v3c_s5, 23'd0}));

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s6    <= sat64(v2a + v2b_w);
			x_s6    <= sat64(v3 + v3c_w);
			temp_s6 <= temp_s5;
			rawp_s6 <= rawp_s5;
		end
	end

	// stage 7: scaled terms, divisor factor
	logic [63:0]        ymag;
	logic signed [63:0] yv;
	logic signed [63:0] v2;
	logic [63:0]        xmag;
	logic [29:0]        xt;
	logic signed [30:0] xf;
	logic signed [62:0] v2_s7;
	logic signed [30:0] x_s7;
	logic signed [14:0] temp_s7;
	logic [19:0]        rawp_s7;

	assign ymag = y_s6[63] ? 64'(-y_s6) : y_s6;
	assign yv   = y_s6[63] ? -$signed({2'b00, ymag[63:2]}) : $signed({2'b00, ymag[63:2]});
	assign v2   = yv + 64'($signed({trim.p4, 40'd0}));
	assign xmag = x_s6[63] ? 64'(-x_s6) : x_s6;
	assign xt   = xmag[63:34];
	assign xf   = x_s6[63] ? 31'sd16777216 - $signed({1'b0, xt})
		: 31'sd16777216 + $signed({1'b0, xt});

	always_ff @(posedge clk) begin
		if (adv) begin
			v2_s7   <= v2[62:0];
			x_s7    <= xf;
			temp_s7 <= temp_s6;
			rawp_s7 <= rawp_s6;
		end
	end

	// stage 8: divisor and numerator before the 6250 scale
	logic [20:0]        dval;
	logic [44:0]        dsh;
	logic [62:0]        vmag;
	logic [50:0]        vq;
	logic [51:0]        nsum;
	logic signed [46:0] div_s8;
	logic signed [51:0] numr_s8;
	logic signed [14:0] temp_s8;

	assign dval = 21'd1048576 - {1'b0, rawp_s7};
	assign dsh  = {dval, 24'd0};
	assign vmag = v2_s7[62] ? 63'(-v2_s7) : v2_s7;
	assign vq   = vmag[62:12];
	assign nsum = v2_s7[62] ? 52'(dsh) + 52'(vq) : 52'(dsh) - 52'(vq);

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s8  <= 47'(x_s7) * 47'($signed({1'b0, trim.p1}));
			numr_s8 <= nsum;
			temp_s8 <= temp_s7;
		end
	end

	// stage 9: operands for the divider
	logic                      bad;
	logic                      numpos;
	logic [bsc_pkg::NUM_W-1:0] num_s9;
	logic [bsc_pkg::DEN_W-1:0] den_s9;
	bsc_pkg::side_t            side_s9;

	assign bad    = div_s8[46] | (div_s8 == 47'sd0);
	assign numpos = ~numr_s8[51] & (numr_s8 != 52'sd0);

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s9 <= (numpos & ~bad) ? bsc_pkg::NUM_W'(numr_s8[50:0]) * bsc_pkg::NUM_W'(6250)
				: '0;
			den_s9 <= bad ? bsc_pkg::DEN_W'(1) : div_s8[bsc_pkg::DEN_W-1:0];
			side_s9.temperature_centi <= temp_s8;
			side_s9.divisor_invalid   <= bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[7:0], in_valid};
		end
	end

	assign out_valid = vld_q[8];
	assign num       = num_s9;
	assign den       = den_s9;
	assign side      = side_s9;

endmodule

// ===== sv/bsc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, saturating quotient
// uses bsc_pkg for widths and the side struct
module bsc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_valid,
	input  logic [bsc_pkg::NUM_W-1:0] num,
	input  logic [bsc_pkg::DEN_W-1:0] den,
	input  bsc_pkg::side_t            side_in,
	output logic                      out_valid,
	output logic [bsc_pkg::QUO_W-1:0] quo,
	output bsc_pkg::side_t            side_out
);

	localparam int QW = bsc_pkg::QUO_W;
	localparam int DW = bsc_pkg::DEN_W + bsc_pkg::QUO_W;

	logic [QW:0]               vld_q;
	logic [bsc_pkg::NUM_W-1:0] rem_s  [0:QW-1];
	logic [bsc_pkg::DEN_W-1:0] den_s  [0:QW-1];
	logic [QW-1:0]             quo_s  [0:QW];
	logic                      ovf_s  [0:QW];
	bsc_pkg::side_t            side_s [0:QW];
	logic [DW-1:0]             trial  [0:QW-1];

	always_comb begin
		for (int k = 0; k < QW; k++) begin
			trial[k] = DW'(rem_s[k]) - (DW'(den_s[k]) << (QW - 1 - k));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// quotient would not fit: saturate at the end
			rem_s[0]  <= num;
			den_s[0]  <= den;
			ovf_s[0]  <= DW'(num) >= {den, QW'(0)};
			quo_s[0]  <= '0;
			side_s[0] <= side_in;
			for (int k = 0; k < QW - 1; k++) begin
				rem_s[k+1] <= trial[k][DW-1] ? rem_s[k] : trial[k][bsc_pkg::NUM_W-1:0];
				den_s[k+1] <= den_s[k];
			end
			for (int k = 0; k < QW; k++) begin
				quo_s[k+1]  <= {quo_s[k][QW-2:0], ~trial[k][DW-1]};
				ovf_s[k+1]  <= ovf_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[QW-1:0], in_valid};
		end
	end

	assign out_valid = vld_q[QW];
	assign quo       = ovf_s[QW] ? '1 : quo_s[QW];
	assign side_out  = side_s[QW];

endmodule

// ===== sv/bsc_back.sv =====
// pressure correction from the quotient, clamping and the output register
// four register stages; uses bsc_pkg
module bsc_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_valid,
	input  logic [bsc_pkg::QUO_W-1:0] quo,
	input  bsc_pkg::side_t            side,
	input  bsc_pkg::trim_t            trim,
	output logic                      out_valid,
	output bsc_pkg::result_t          result
);

	logic [3:0]  vld_q;
	logic [15:0] m8;
	logic [15:0] m9;

	assign m8 = bsc_pkg::mag16(trim.p8);
	assign m9 = bsc_pkg::mag16(trim.p9);

	// stage 1
	logic [63:0]               q2_s1;
	logic [47:0]               qm8_s1;
	logic [bsc_pkg::QUO_W-1:0] q_s1;
	bsc_pkg::side_t            side_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			q2_s1   <= 64'(quo) * 64'(quo);
			qm8_s1  <= 48'(quo) * 48'(m8);
			q_s1    <= quo;
			side_s1 <= side;
		end
	end

	// stage 2
	logic signed [57:0]        w2;
	logic                      sat_s2;
	logic [54:0]               w1p_s2;
	logic signed [57:0]        w2_s2;
	logic [bsc_pkg::QUO_W-1:0] q_s2;
	bsc_pkg::side_t            side_s2;

	assign w2 = trim.p8[15] ? -$signed({1'b0, qm8_s1, 9'd0}) : $signed({1'b0, qm8_s1, 9'd0});

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s2  <= |q2_s1[63:39];
			w1p_s2  <= 55'(q2_s1[38:0]) * 55'(m9);
			w2_s2   <= w2;
			q_s2    <= q_s1;
			side_s2 <= side_s1;
		end
	end

	// stage 3
	logic [47:0]               w1mag;
	logic signed [48:0]        w1;
	logic signed [58:0]        s_sum;
	logic signed [58:0]        s_s3;
	logic [bsc_pkg::QUO_W-1:0] q_s3;
	bsc_pkg::side_t            side_s3;

	// saturated square of the quotient scaled by p9 over 2^31
	assign w1mag = sat_s2 ? ((m9 == 16'd0) ? 48'd0 : {m9, 32'd0} - 48'd1) : w1p_s2[54:7];
	assign w1    = trim.p9[15] ? -$signed({1'b0, w1mag}) : $signed({1'b0, w1mag});
	assign s_sum = 59'(w1) + 59'(w2_s2) + 59'($signed({trim.p7, 24'd0}));

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s3    <= s_sum;
			q_s3    <= q_s2;
			side_s3 <= side_s2;
		end
	end

	// stage 4: final sum and clamp into the output register
	logic [58:0]        smag;
	logic signed [58:0] tv;
	logic signed [59:0] r;
	logic [35:0]        rp;
	logic [16:0]        pres;
	bsc_pkg::result_t   result_s4;

	assign smag = s_s3[58] ? 59'(-s_s3) : s_s3;
	assign tv   = s_s3[58] ? -$signed({4'd0, smag[58:4]}) : $signed({4'd0, smag[58:4]});
	assign r    = $signed({4'd0, q_s3, 24'd0}) + 60'(tv);
	assign rp   = r[59:24];

	always_comb begin
		if (side_s3.divisor_invalid || r[59]) begin
			pres = bsc_pkg::PRES_MIN;
		end else if (rp < 36'(bsc_pkg::PRES_MIN)) begin
			pres = bsc_pkg::PRES_MIN;
		end else if (rp > 36'(bsc_pkg::PRES_MAX)) begin
			pres = bsc_pkg::PRES_MAX;
		end else begin
			pres = rp[16:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s4.temperature_centi <= side_s3.temperature_centi;
			result_s4.pressure_pa       <= pres;
			result_s4.divisor_invalid   <= side_s3.divisor_invalid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[2:0], in_valid};
		end
	end

	assign out_valid = vld_q[3];
	assign result    = result_s4;

endmodule

// ===== sv/baro_sensor_compensation_core.sv =====
// an accepted sample word passes through bsc_front, bsc_div and bsc_back in order to its result word
// throughput: one word per cycle while no result is stalled; the 33-stage divider sets the depth
// the whole pipeline advances together and freezes only while a result is stalled
// reset: arst_n clears all valid bits and the trim registers to zero
// files: bsc_pkg, bsc_front, bsc_div, bsc_back
module baro_sensor_compensation_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  bsc_pkg::sample_t               sample,
	output logic                           result_valid,
	input  logic                           result_stall,
	output bsc_pkg::result_t               result,
	input  logic                           cfg_we,
	input  logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data
);

	// trim registers; the user must write them only while the pipeline is empty, the block does not enforce it
	logic [47:0] temp_trim_q;
	logic [63:0] pres_a_q;
	logic [63:0] pres_b_q;
	logic [15:0] pres_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_trim_q <= '0;
			pres_a_q    <= '0;
			pres_b_q    <= '0;
			pres_c_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bsc_pkg::REG_TEMP_TRIM: temp_trim_q <= cfg_data[47:0];
				bsc_pkg::REG_PRES_A:    pres_a_q    <= cfg_data;
				bsc_pkg::REG_PRES_B:    pres_b_q    <= cfg_data;
				bsc_pkg::REG_PRES_C:    pres_c_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// unpack the twelve trim words
	bsc_pkg::trim_t trim;

	always_comb begin
		trim.t1 = temp_trim_q[15:0];
		trim.t2 = temp_trim_q[31:16];
		trim.t3 = temp_trim_q[47:32];
		trim.p1 = pres_a_q[15:0];
		trim.p2 = pres_a_q[31:16];
		trim.p3 = pres_a_q[47:32];
		trim.p4 = pres_a_q[63:48];
		trim.p5 = pres_b_q[15:0];
		trim.p6 = pres_b_q[31:16];
		trim.p7 = pres_b_q[47:32];
		trim.p8 = pres_b_q[63:48];
		trim.p9 = pres_c_q;
	end

	// one advance for every stage: hold everything while the output word waits
	logic adv;

	assign adv          = ~(result_valid & result_stall);
	assign sample_stall = ~adv;

	// front: temperature and pressure polynomial, divider operands
	logic                      front_valid;
	logic [bsc_pkg::NUM_W-1:0] front_num;
	logic [bsc_pkg::DEN_W-1:0] front_den;
	bsc_pkg::side_t            front_side;

	bsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (sample_valid),
		.sample    (sample),
		.trim      (trim),
		.out_valid (front_valid),
		.num       (front_num),
		.den       (front_den),
		.side      (front_side)
	);

	// quotient of the scaled numerator by the divisor, capped at 32 bits
	logic                      div_valid;
	logic [bsc_pkg::QUO_W-1:0] div_quo;
	bsc_pkg::side_t            div_side;

	bsc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (front_valid),
		.num       (front_num),
		.den       (front_den),
		.side_in   (front_side),
		.out_valid (div_valid),
		.quo       (div_quo),
		.side_out  (div_side)
	);

	// second order correction, clamp and output register
	bsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (div_valid),
		.quo       (div_quo),
		.side      (div_side),
		.trim      (trim),
		.out_valid (result_valid),
		.result    (result)
	);

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for baro_sensor_compensation_core
// depends on bsc_pkg and the core; predicts each result word in a scoreboard class
`timescale 1ns / 100ps

module tb;

	localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint Q_ONE   = 64'sd16777216;

	// trim sets used by the phases
	typedef enum int {
		TRIM_TYPICAL, TRIM_JITTER, TRIM_ONES, TRIM_POS_MAX, TRIM_NEG_MAX, TRIM_RANDOM,
		TRIM_NO_P1
	} trim_kind_e;

	class compensation_scoreboard;
		logic [63:0]      trim_regs [4];
		bsc_pkg::result_t pending_results [$];
		int               fails;

		function new();
			foreach (trim_regs[i]) trim_regs[i] = '0;
			fails = 0;
		endfunction

		function void write_reg(logic [bsc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
			case (idx)
				bsc_pkg::REG_TEMP_TRIM: trim_regs[0] = {16'd0, data[47:0]};
				bsc_pkg::REG_PRES_A:    trim_regs[1] = data;
				bsc_pkg::REG_PRES_B:    trim_regs[2] = data;
				bsc_pkg::REG_PRES_C:    trim_regs[3] = {48'd0, data[15:0]};
				default: ;
			endcase
		endfunction

		function logic [63:0] magnitude(longint a);
			logic [63:0] u;
			u = a;
			return (a < 0) ? (~u + 64'd1) : u;
		endfunction

		function longint from_mag(logic [63:0] m, bit neg);
			if (m > 64'h7FFF_FFFF_FFFF_FFFF)
				m = 64'h7FFF_FFFF_FFFF_FFFF;
			return neg ? -longint'(m) : longint'(m);
		endfunction

		// exact product, scaled down by 2^sh toward zero, saturated
		function longint mul_scaled(longint a, longint b, int sh);
			logic [127:0] p;
			logic [63:0]  m;
			p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
			p = p >> sh;
			m = (p[127:64] != 0) ? 64'h7FFF_FFFF_FFFF_FFFF : p[63:0];
			return from_mag(m, (a < 0) != (b < 0));
		endfunction

		function longint shift_down(longint a, int sh);
			return from_mag(magnitude(a) >> sh, a < 0);
		endfunction

		function longint add_sat(longint a, longint b);
			if (b > 0 && a > SAT_MAX - b)
				return SAT_MAX;
			if (b < 0 && a < -SAT_MAX - b)
				return -SAT_MAX;
			return a + b;
		endfunction

		function void note_sample(bsc_pkg::sample_t s);
			longint adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
			longint a, b, fine, temp, v1, v1sq, v2, v3, dvsr, num, pq, w1, w2, r;
			logic [63:0] q;
			bsc_pkg::result_t exp_r;
			adc_t = {44'd0, s.raw_temperature};
			adc_p = {44'd0, s.raw_pressure};
			t1 = {48'd0, trim_regs[0][15:0]};
			t2 = $signed(trim_regs[0][31:16]);
			t3 = $signed(trim_regs[0][47:32]);
			p1 = {48'd0, trim_regs[1][15:0]};
			p2 = $signed(trim_regs[1][31:16]);
			p3 = $signed(trim_regs[1][47:32]);
			p4 = $signed(trim_regs[1][63:48]);
			p5 = $signed(trim_regs[2][15:0]);
			p6 = $signed(trim_regs[2][31:16]);
			p7 = $signed(trim_regs[2][47:32]);
			p8 = $signed(trim_regs[2][63:48]);
			p9 = $signed(trim_regs[3][15:0]);

			// integer temperature path, divisions truncate toward zero
			a = ((adc_t / 8 - t1 * 2) * t2) / 2048;
			b = adc_t / 16 - t1;
			b = ((b * b) / 4096 * t3) / 16384;
			fine = a + b;
			temp = (fine * 5 + 128) / 256;
			if (temp < -4000)
				temp = -4000;
			else if (temp > 8500)
				temp = 8500;

			// pressure in q40.24
			v1 = fine * 64'sd8388608 - 64'sd64000 * Q_ONE;
			v1sq = mul_scaled(v1, v1, 24);
			v2 = mul_scaled(v1sq, p6, 15);
			v2 = add_sat(v2, mul_scaled(v1, p5 * 2, 0));
			v2 = add_sat(shift_down(v2, 2), p4 * 64'sh100_0000_0000);
			v3 = mul_scaled(v1sq, p3, 19);
			v1 = shift_down(add_sat(v3, mul_scaled(v1, p2, 0)), 19);
			dvsr = mul_scaled(add_sat(Q_ONE, shift_down(v1, 15)), p1, 0);

			exp_r.temperature_centi = temp[14:0];
			exp_r.pressure_pa = bsc_pkg::PRES_MIN;
			exp_r.divisor_invalid = 1'b1;
			if (dvsr > 0) begin
				num = add_sat((64'sd1048576 - adc_p) * Q_ONE, -shift_down(v2, 12));
				num = mul_scaled(num, 6250, 0);
				if (num <= 0)
					q = '0;
				else begin
					q = num / dvsr;
					if (q > 64'hFFFF_FFFF)
						q = 64'hFFFF_FFFF;
				end
				pq = q << 24;
				w1 = mul_scaled(mul_scaled(pq, pq, 24), p9, 31);
				w2 = mul_scaled(pq, p8, 15);
				r = add_sat(pq, shift_down(add_sat(add_sat(w1, w2), p7 * Q_ONE), 4));
				if (r >= 0) begin
					r = r >>> 24;
					if (r < 30000)
						r = 30000;
					else if (r > 110000)
						r = 110000;
					exp_r.pressure_pa = r[16:0];
				end
				exp_r.divisor_invalid = 1'b0;
			end
			pending_results.push_back(exp_r);
		endfunction

		function void check_result(bsc_pkg::result_t got);
			bsc_pkg::result_t exp_r;
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result word: actual %h", $time, got);
				fails++;
				return;
			end
			exp_r = pending_results.pop_front();
			if (got.temperature_centi !== exp_r.temperature_centi) begin
				$display("%0t temperature_centi: expected %0d actual %0d", $time,
					exp_r.temperature_centi, got.temperature_centi);
				fails++;
			end
			if (got.pressure_pa !== exp_r.pressure_pa) begin
				$display("%0t pressure_pa: expected %0d actual %0d", $time,
					exp_r.pressure_pa, got.pressure_pa);
				fails++;
			end
			if (got.divisor_invalid !== exp_r.divisor_invalid) begin
				$display("%0t divisor_invalid: expected %0b actual %0b", $time,
					exp_r.divisor_invalid, got.divisor_invalid);
				fails++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           sample_valid;
	logic                           sample_stall;
	bsc_pkg::sample_t               sample;
	logic                           result_valid;
	logic                           result_stall;
	bsc_pkg::result_t               result;
	logic                           cfg_we;
	logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data;

	compensation_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	baro_sensor_compensation_core dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// receiver stalls at random, one decision per cycle
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// both monitors sample the values present at the edge
	always @(posedge clk) begin
		if (arst_n && sample_valid && !sample_stall)
			sb.note_sample(sample);
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	task automatic write_cfg(logic [bsc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one sample word; each cycle in front of it idles with the set chance
	task automatic send_word(logic [19:0] raw_t, logic [19:0] raw_p);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= '{raw_temperature: raw_t, raw_pressure: raw_p};
		do @(posedge clk); while (!(sample_valid && !sample_stall));
	endtask

	task automatic wait_results;
		while (sb.pending_results.size() != 0) @(posedge clk);
	endtask

	// every result in, then enough cycles for the pipeline to be empty
	task automatic drain;
		sample_valid <= 1'b0;
		@(posedge clk);
		wait_results();
		repeat (50) @(posedge clk);
	endtask

	task automatic load_trims(trim_kind_e kind);
		logic [15:0] w [12];
		logic [15:0] typical [12];
		typical = '{16'd27504, 16'd26435, -16'sd1000, 16'd36477, -16'sd10685, 16'd3024,
			16'd2855, 16'd140, -16'sd7, 16'd15500, -16'sd14600, 16'd6000};
		foreach (w[i]) begin
			case (kind)
				TRIM_TYPICAL: w[i] = typical[i];
				TRIM_JITTER:  w[i] = typical[i] + 16'($urandom_range(0, 63)) - 16'd32;
				TRIM_ONES:    w[i] = 16'hFFFF;
				TRIM_POS_MAX: w[i] = 16'h7FFF;
				TRIM_NEG_MAX: w[i] = 16'h8000;
				TRIM_RANDOM:  w[i] = 16'($urandom);
				default:      w[i] = typical[i];
			endcase
		end
		if (kind == TRIM_POS_MAX) begin
			w[0] = 16'hFFFF;
			w[3] = 16'hFFFF;
		end
		if (kind == TRIM_NO_P1)
			w[3] = 16'd0;
		// junk in the unused upper bits checks the register masking
		write_cfg(bsc_pkg::REG_TEMP_TRIM, {16'($urandom), w[2], w[1], w[0]});
		write_cfg(bsc_pkg::REG_PRES_A, {w[6], w[5], w[4], w[3]});
		write_cfg(bsc_pkg::REG_PRES_B, {w[10], w[9], w[8], w[7]});
		write_cfg(bsc_pkg::REG_PRES_C, {48'($urandom), w[11]});
	endtask

	task automatic send_random;
		if ($urandom_range(9) < 7)
			send_word(20'($urandom_range(400000, 640000)),
				20'($urandom_range(250000, 650000)));
		else
			send_word(20'($urandom), 20'($urandom));
	endtask

	initial begin
		trim_kind_e phase_kind [8];
		phase_kind = '{TRIM_JITTER, TRIM_ONES, TRIM_JITTER, TRIM_POS_MAX, TRIM_NEG_MAX,
			TRIM_RANDOM, TRIM_JITTER, TRIM_NO_P1};
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		result_stall <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset trims: divisor is zero, so the flag path is taken
		send_word(20'h00000, 20'h00000);
		send_word(20'hFFFFF, 20'hFFFFF);
		send_word(20'd519888, 20'd415148);
		drain();

		// typical trims, field extremes and a nominal reading
		load_trims(TRIM_TYPICAL);
		send_word(20'd519888, 20'd415148);
		send_word(20'h00000, 20'd415148);
		send_word(20'hFFFFF, 20'd415148);
		send_word(20'h80000, 20'h00000);
		send_word(20'd519888, 20'h00000);
		send_word(20'd519888, 20'hFFFFF);
		send_word(20'h7FFFF, 20'h80000);
		send_word(20'h55555, 20'hAAAAA);
		send_word(20'hAAAAA, 20'h55555);
		send_word(20'd300000, 20'd600000);
		send_word(20'd700000, 20'd200000);
		drain();

		foreach (phase_kind[ph]) begin
			load_trims(phase_kind[ph]);
			if (ph < 3) begin
				send_idle_pct = 13;
				recv_stall_pct = 58;
			end else if (ph < 6) begin
				send_idle_pct = 58;
				recv_stall_pct = 13;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			for (int i = 0; i < 185; i++) begin
				// hold off until the pipeline has delivered everything
				if (ph == 0 && i == 90) begin
					sample_valid <= 1'b0;
					@(posedge clk);
					wait_results();
				end
				send_random();
			end
			drain();
		end

		if (sb.fails == 0 && sb.pending_results.size() == 0)
			$display("[baro_sensor_compensation_core] OK");
		else
			$display("[baro_sensor_compensation_core] ERROR");
		$finish;
	end

	// run limit
	initial begin
		#5ms;
		$display("[baro_sensor_compensation_core] ERROR");
		$finish;
	end

endmodule
